### rtl/ybd_pkg.sv
// shared types, constants and sigmoid table for the yolo box decode unit
package ybd_pkg;

    localparam int MAX_CLASSES = 80;
    localparam int GRID_MAX    = 256;
    localparam int SIG_ENTRIES = 1024;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASSES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHORS0  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHORS1  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHORS2  = 3'd7;

    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [15:0]            threshold;
        logic [6:0]             class_count;
        logic [2:0][7:0]        stride;
        logic [2:0][59:0]       anchors;
    } t_cfg;

    typedef logic [SIG_ENTRIES-1:0][15:0] t_sig_rom;

    function automatic t_sig_rom build_sig_rom();
        t_sig_rom    rom;
        logic [63:0] one;
        logic [63:0] z;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] t4;
        logic [63:0] e;
        logic [63:0] s;
        logic [63:0] den;
        logic [63:0] rem;
        one = 64'd1 << 31;
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            z  = (64'(i) << 27) / SIG_ENTRIES;
            t2 = ((z * z) >> 31) / 2;
            t3 = ((t2 * z) >> 31) / 3;
            t4 = ((t3 * z) >> 31) / 4;
            e  = one - z + t2 - t3 + t4;
            for (int k = 0; k < 8; k++) begin
                e = (e * e) >> 31;
            end
            // restoring long division of 2^47 by one + e
            den = one + e;
            rem = '0;
            s   = '0;
            for (int b = 47; b >= 0; b--) begin
                rem = {rem[62:0], (b == 47)};
                s   = {s[62:0], 1'b0};
                if (rem >= den) begin
                    rem  = rem - den;
                    s[0] = 1'b1;
                end
            end
            if (s > 64'd65535) begin
                s = 64'd65535;
            end
            rom[i] = s[15:0];
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = build_sig_rom();

endpackage

### rtl/ybd_if.sv
// valid/ready channel interfaces for logit items and decoded boxes
interface ybd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] logit;
    logic [1:0]         scale_sel;
    logic [1:0]         anchor_sel;
    logic [7:0]         grid_col;
    logic [7:0]         grid_row;
    logic               last_element;

    modport source (
        output valid, logit, scale_sel, anchor_sel, grid_col, grid_row, last_element,
        input  ready
    );
    modport sink (
        input  valid, logit, scale_sel, anchor_sel, grid_col, grid_row, last_element,
        output ready
    );
endinterface

interface ybd_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] left;
    logic signed [19:0] top;
    logic signed [19:0] right;
    logic signed [19:0] bottom;
    logic [15:0]        confidence;
    logic [6:0]         class_id;

    modport source (
        output valid, left, top, right, bottom, confidence, class_id,
        input  ready
    );
    modport sink (
        input  valid, left, top, right, bottom, confidence, class_id,
        output ready
    );
endinterface

### rtl/ybd_cfg.sv
// configuration register file
module ybd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ybd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ybd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ybd_pkg::t_cfg                  o_cfg
);

    ybd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold   <= 16'd16384;
            r_cfg.class_count <= 7'd80;
            r_cfg.stride[0]   <= 8'd8;
            r_cfg.stride[1]   <= 8'd16;
            r_cfg.stride[2]   <= 8'd32;
            r_cfg.anchors[0]  <= '0;
            r_cfg.anchors[1]  <= '0;
            r_cfg.anchors[2]  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ybd_pkg::CFG_THRESHOLD: r_cfg.threshold   <= i_cfg_data[15:0];
                ybd_pkg::CFG_CLASSES:   r_cfg.class_count <= i_cfg_data[6:0];
                ybd_pkg::CFG_STRIDE0:   r_cfg.stride[0]   <= i_cfg_data[7:0];
                ybd_pkg::CFG_STRIDE1:   r_cfg.stride[1]   <= i_cfg_data[7:0];
                ybd_pkg::CFG_STRIDE2:   r_cfg.stride[2]   <= i_cfg_data[7:0];
                ybd_pkg::CFG_ANCHORS0:  r_cfg.anchors[0]  <= i_cfg_data[59:0];
                ybd_pkg::CFG_ANCHORS1:  r_cfg.anchors[1]  <= i_cfg_data[59:0];
                ybd_pkg::CFG_ANCHORS2:  r_cfg.anchors[2]  <= i_cfg_data[59:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/ybd_sigmoid.sv
// table sigmoid: registered index stage, then registered table read
module ybd_sigmoid (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic signed [15:0] i_logit,
    output logic [16:0]        o_s
);

    logic [16:0]                    mag;
    logic [29:0]                    scaled;
    logic [17:0]                    idx_full;
    logic [ybd_pkg::SIG_IDX_W-1:0]  n_idx;
    logic [ybd_pkg::SIG_IDX_W-1:0]  r_idx;
    logic                           r_neg;
    logic [15:0]                    rom_q;
    logic [16:0]                    r_s;

    always_comb begin
        mag      = i_logit[15] ? (17'h10000 - {1'b0, i_logit}) : {1'b0, i_logit};
        scaled   = 30'(mag) * 30'(ybd_pkg::SIG_ENTRIES);
        idx_full = scaled[29:12];
        if (idx_full >= 18'(ybd_pkg::SIG_ENTRIES)) begin
            n_idx = ybd_pkg::SIG_IDX_W'(ybd_pkg::SIG_ENTRIES - 1);
        end else begin
            n_idx = idx_full[ybd_pkg::SIG_IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_idx <= n_idx;
            r_neg <= i_logit[15];
        end
    end

    assign rom_q = ybd_pkg::SIG_ROM[r_idx];

    always_ff @(posedge i_clk) begin
        r_s <= r_neg ? (17'h10000 - {1'b0, rom_q}) : {1'b0, rom_q};
    end

    assign o_s = r_s;

endmodule

### rtl/ybd_mul.sv
// shared signed multiplier with registered product
module ybd_mul (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [ybd_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [ybd_pkg::MUL_B_W-1:0] i_b,
    output logic signed [ybd_pkg::MUL_P_W-1:0] o_p
);

    logic signed [ybd_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

### rtl/yolo_box_decode_unit.sv
// yolo box decoder top level: sequencer, prediction state and result register
// an item runs S_ROM, S_EVAL, S_FIN before the next ready (class and objectness terms);
// a centre term adds S_STORE, a size term adds S_MUL2 and S_STORE (two passes through
// the multiplier); the last class term adds S_CONF and S_CMP, where its box is loaded
// into the result register once that register is free; one item is in work at a time
// synchronous active-low reset restores register defaults and clears the prediction state
module yolo_box_decode_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ybd_in_if.sink                         i_in,
    ybd_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [ybd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ybd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROM   = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_CONF  = 3'd6;
    localparam logic [2:0] S_CMP   = 3'd7;

    function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
        logic signed [19:0] r;
        if (v > 22'sd524287) begin
            r = 20'sd524287;
        end else if (v < -22'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

    ybd_pkg::t_cfg cfg;

    logic [2:0]         r_state;
    logic [1:0]         r_sc;
    logic [1:0]         r_an;
    logic [7:0]         r_col;
    logic [7:0]         r_row;
    logic               r_last;
    logic [6:0]         r_elem;
    logic signed [20:0] r_cx;
    logic signed [20:0] r_cy;
    logic [16:0]        r_bw;
    logic [16:0]        r_bh;
    logic [15:0]        r_obj;
    logic [15:0]        r_best;
    logic [6:0]         r_bclass;

    logic               r_ov;
    logic signed [19:0] r_left;
    logic signed [19:0] r_top;
    logic signed [19:0] r_right;
    logic signed [19:0] r_bottom;
    logic [15:0]        r_conf;
    logic [6:0]         r_cls;

    logic                               accept;
    logic [16:0]                        s;
    logic [17:0]                        t;
    logic [7:0]                         grid;
    logic [7:0]                         grid_c;
    logic signed [25:0]                 v;
    logic [7:0]                         stride;
    logic [59:0]                        anchors;
    logic [19:0]                        anchor_wh;
    logic [9:0]                         anchor;
    logic [6:0]                         ncls;
    logic [6:0]                         cls_idx;
    logic                               mul_en;
    logic signed [ybd_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ybd_pkg::MUL_B_W-1:0] mul_b;
    logic signed [ybd_pkg::MUL_P_W-1:0] prod;
    logic [15:0]                        conf;
    logic                               pass;
    logic                               out_free;
    logic                               box_load;
    logic signed [21:0]                 hw;
    logic signed [21:0]                 hh;

    ybd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ybd_sigmoid u_sigmoid (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_logit (i_in.logit),
        .o_s     (s)
    );

    ybd_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && (r_state == S_IDLE);

    always_comb begin
        t       = {s, 1'b0};
        grid    = (r_elem == 7'd0) ? r_col : r_row;
        if (32'(grid) >= 32'(ybd_pkg::GRID_MAX)) begin
            grid_c = 8'(ybd_pkg::GRID_MAX - 1);
        end else begin
            grid_c = grid;
        end
        v       = $signed({8'd0, s, 1'b0}) - 26'sd32768 + $signed({2'b00, grid_c, 16'd0});
        stride  = cfg.stride[r_sc];
        anchors = cfg.anchors[r_sc];
        case (r_an)
            2'd0:    anchor_wh = anchors[19:0];
            2'd1:    anchor_wh = anchors[39:20];
            default: anchor_wh = anchors[59:40];
        endcase
        anchor  = (r_elem == 7'd2) ? anchor_wh[9:0] : anchor_wh[19:10];
        if (cfg.class_count == 7'd0) begin
            ncls = 7'd1;
        end else if (cfg.class_count > 7'(ybd_pkg::MAX_CLASSES)) begin
            ncls = 7'(ybd_pkg::MAX_CLASSES);
        end else begin
            ncls = cfg.class_count;
        end
        cls_idx  = r_elem - 7'd5;
        conf     = prod[31:16];
        pass     = conf > cfg.threshold;
        out_free = !r_ov || o_out.ready;
        box_load = (r_state == S_CMP) && pass && out_free;
        hw       = $signed({6'd0, r_bw[16:1]});
        hh       = $signed({6'd0, r_bh[16:1]});
    end

    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_EVAL: begin
                if (r_elem == 7'd0 || r_elem == 7'd1) begin
                    mul_en = 1'b1;
                    mul_a  = ybd_pkg::MUL_A_W'(v);
                    mul_b  = $signed({11'd0, stride});
                end else if (r_elem == 7'd2 || r_elem == 7'd3) begin
                    mul_en = 1'b1;
                    mul_a  = $signed({17'd0, t});
                    mul_b  = $signed({1'b0, t});
                end
            end
            S_MUL2: begin
                mul_en = 1'b1;
                mul_a  = $signed({1'b0, prod[33:0]});
                mul_b  = $signed({9'd0, anchor});
            end
            S_CONF: begin
                mul_en = 1'b1;
                mul_a  = $signed({19'd0, r_obj});
                mul_b  = $signed({3'd0, r_best});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sc  <= (i_in.scale_sel == 2'd3) ? 2'd2 : i_in.scale_sel;
            r_an  <= (i_in.anchor_sel == 2'd3) ? 2'd2 : i_in.anchor_sel;
            r_col <= i_in.grid_col;
            r_row <= i_in.grid_row;
            r_last <= i_in.last_element;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_elem   <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_bw     <= '0;
            r_bh     <= '0;
            r_obj    <= '0;
            r_best   <= '0;
            r_bclass <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (box_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_ROM;
                    end
                end
                S_ROM: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_elem == 7'd0 || r_elem == 7'd1) begin
                        r_state <= S_STORE;
                    end else if (r_elem == 7'd2 || r_elem == 7'd3) begin
                        r_state <= S_MUL2;
                    end else begin
                        if (r_elem == 7'd4) begin
                            r_obj <= s[15:0];
                        end else if (cls_idx == 7'd0) begin
                            r_best   <= s[15:0];
                            r_bclass <= '0;
                        end else if (cls_idx < ncls && s > {1'b0, r_best}) begin
                            r_best   <= s[15:0];
                            r_bclass <= cls_idx;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_MUL2: begin
                    r_state <= S_STORE;
                end
                S_STORE: begin
                    case (r_elem)
                        7'd0:    r_cx <= prod[32:12];
                        7'd1:    r_cy <= prod[32:12];
                        7'd2:    r_bw <= prod[44:28];
                        default: r_bh <= prod[44:28];
                    endcase
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_last) begin
                        if (r_elem >= 7'd5) begin
                            r_state <= S_CONF;
                        end else begin
                            r_elem  <= '0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (r_elem != 7'd127) begin
                            r_elem <= r_elem + 7'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_CONF: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!pass) begin
                        r_elem  <= '0;
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_elem  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (box_load) begin
            r_left   <= sat20(22'(r_cx) - hw);
            r_top    <= sat20(22'(r_cy) - hh);
            r_right  <= sat20(22'(r_cx) + hw);
            r_bottom <= sat20(22'(r_cy) + hh);
            r_conf   <= conf;
            r_cls    <= r_bclass;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.left       = r_left;
    assign o_out.top        = r_top;
    assign o_out.right      = r_right;
    assign o_out.bottom     = r_bottom;
    assign o_out.confidence = r_conf;
    assign o_out.class_id   = r_cls;

endmodule

### tb/tb_yolo_box_decode_unit.sv
`timescale 1ns / 1ps
// testbench for the yolo box decode unit: directed table, random predictions, box scoreboard
module tb_yolo_box_decode_unit;

    typedef struct {
        logic signed [15:0] logit;
        logic [1:0]         scale_sel;
        logic [1:0]         anchor_sel;
        logic [7:0]         grid_col;
        logic [7:0]         grid_row;
        logic               last_element;
    } t_logit_item;

    typedef struct {
        logic signed [19:0] left;
        logic signed [19:0] top;
        logic signed [19:0] right;
        logic signed [19:0] bottom;
        logic [15:0]        confidence;
        logic [6:0]         class_id;
    } t_box;

    typedef enum {ROW_PRED, ROW_BOX, ROW_NONE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        t_logit_item                    it;
        t_box                           box;
        logic [ybd_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [ybd_pkg::CFG_DATA_W-1:0] reg_val;
    } t_stim_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [ybd_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [ybd_pkg::CFG_DATA_W-1:0] cfg_data;

    ybd_in_if  in_if ();
    ybd_out_if out_if ();

    yolo_box_decode_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // shadow registers and prediction state
    logic [15:0]     logistic_tab [ybd_pkg::SIG_ENTRIES];
    logic [15:0]     thr_q;
    logic [6:0]      ncls_q;
    logic [7:0]      stride_q [3];
    logic [59:0]     anchor_q [3];
    int              elem_n;
    longint          cx;
    longint          cy;
    longint unsigned bw;
    longint unsigned bh;
    int unsigned     obj;
    int unsigned     best;
    int unsigned     best_cls;

    t_box      pending_boxes [$];
    t_stim_row dir_q [$];
    int        mismatches;
    int        items_sent;
    int        boxes_seen;
    bit        no_idle;
    bit        hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d boxes still pending", pending_boxes.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic void fill_logistic_tab();
        longint unsigned q31;
        longint unsigned x;
        longint unsigned p2;
        longint unsigned p3;
        longint unsigned p4;
        longint unsigned ex;
        longint unsigned q;
        q31 = 64'd1 << 31;
        for (int i = 0; i < ybd_pkg::SIG_ENTRIES; i++) begin
            x  = (64'(i) << 27) / 64'(ybd_pkg::SIG_ENTRIES);
            p2 = ((x * x) >> 31) / 2;
            p3 = ((p2 * x) >> 31) / 3;
            p4 = ((p3 * x) >> 31) / 4;
            ex = q31 - x + p2 - p3 + p4;
            repeat (8) ex = (ex * ex) >> 31;
            q = (64'd1 << 47) / (q31 + ex);
            logistic_tab[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        end
    endfunction

    function automatic int unsigned logistic_q16(input logic [15:0] raw);
        int unsigned mag;
        int unsigned idx;
        mag = raw[15] ? (32'h10000 - 32'(raw)) : 32'(raw);
        idx = (mag * ybd_pkg::SIG_ENTRIES) / 4096;
        if (idx > ybd_pkg::SIG_ENTRIES - 1) idx = ybd_pkg::SIG_ENTRIES - 1;
        return raw[15] ? (32'd65536 - 32'(logistic_tab[idx])) : 32'(logistic_tab[idx]);
    endfunction

    function automatic longint centre_q4(input int unsigned s, input logic [7:0] g,
                                         input logic [7:0] st);
        longint v;
        v = 2 * longint'(s) - 32768 + (longint'(g) << 16);
        return (v * longint'(st)) >>> 12;
    endfunction

    function automatic longint unsigned size_q4(input int unsigned s, input logic [9:0] a);
        longint unsigned t;
        t = 64'(s) * 2;
        return (t * t * 64'(a)) >> 28;
    endfunction

    function automatic logic signed [19:0] sat20(input longint v);
        if (v > 524287) return 20'sh7FFFF;
        if (v < -524288) return 20'sh80000;
        return v[19:0];
    endfunction

    function automatic bit decode_logit(input t_logit_item it, output t_box bx);
        int unsigned     s;
        int unsigned     sc;
        int unsigned     an;
        int unsigned     nc;
        int unsigned     c;
        longint unsigned conf;
        logic [59:0]     anc;
        bit              emit;
        emit = 1'b0;
        bx   = '{default: '0};
        s    = logistic_q16(it.logit);
        sc   = (it.scale_sel == 2'd3) ? 2 : 32'(it.scale_sel);
        an   = (it.anchor_sel == 2'd3) ? 2 : 32'(it.anchor_sel);
        anc  = anchor_q[sc];
        nc   = 32'(ncls_q);
        if (nc < 1) nc = 1;
        if (nc > ybd_pkg::MAX_CLASSES) nc = ybd_pkg::MAX_CLASSES;
        case (elem_n)
            0: cx = centre_q4(s, it.grid_col, stride_q[sc]);
            1: cy = centre_q4(s, it.grid_row, stride_q[sc]);
            2: bw = size_q4(s, anc[20*an +: 10]);
            3: bh = size_q4(s, anc[20*an+10 +: 10]);
            4: obj = s;
            default: begin
                c = elem_n - 5;
                if (c == 0) begin
                    best     = s;
                    best_cls = 0;
                end else if (c < nc && s > best) begin
                    best     = s;
                    best_cls = c;
                end
            end
        endcase
        if (it.last_element) begin
            if (elem_n >= 5) begin
                conf = (64'(obj) * 64'(best)) >> 16;
                if (conf > 64'(thr_q)) begin
                    bx.left       = sat20(cx - longint'(bw >> 1));
                    bx.top        = sat20(cy - longint'(bh >> 1));
                    bx.right      = sat20(cx + longint'(bw >> 1));
                    bx.bottom     = sat20(cy + longint'(bh >> 1));
                    bx.confidence = conf[15:0];
                    bx.class_id   = best_cls[6:0];
                    emit          = 1'b1;
                end
            end
            elem_n = 0;
        end else if (elem_n < 127) begin
            elem_n++;
        end
        return emit;
    endfunction

    function automatic t_stim_row it_row(input t_row_kind k, input logic [15:0] lg,
                                         input logic [1:0] sc, input logic [1:0] an,
                                         input logic [7:0] col, input logic [7:0] row,
                                         input logic last);
        t_stim_row r;
        r.kind            = k;
        r.it.logit        = lg;
        r.it.scale_sel    = sc;
        r.it.anchor_sel   = an;
        r.it.grid_col     = col;
        r.it.grid_row     = row;
        r.it.last_element = last;
        r.box             = '{default: '0};
        r.reg_idx         = '0;
        r.reg_val         = '0;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [ybd_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [ybd_pkg::CFG_DATA_W-1:0] val);
        t_stim_row r;
        r         = it_row(ROW_CFG, '0, '0, '0, '0, '0, 1'b0);
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_box();
        t_box want;
        boxes_seen++;
        if (pending_boxes.size() == 0) begin
            flag_mismatch("box arrived with none pending");
            return;
        end
        want = pending_boxes.pop_front();
        if (out_if.left !== want.left)
            flag_mismatch($sformatf("left %0d, wanted %0d", out_if.left, want.left));
        if (out_if.top !== want.top)
            flag_mismatch($sformatf("top %0d, wanted %0d", out_if.top, want.top));
        if (out_if.right !== want.right)
            flag_mismatch($sformatf("right %0d, wanted %0d", out_if.right, want.right));
        if (out_if.bottom !== want.bottom)
            flag_mismatch($sformatf("bottom %0d, wanted %0d", out_if.bottom, want.bottom));
        if (out_if.confidence !== want.confidence)
            flag_mismatch($sformatf("confidence %0d, wanted %0d",
                                    out_if.confidence, want.confidence));
        if (out_if.class_id !== want.class_id)
            flag_mismatch($sformatf("class_id %0d, wanted %0d",
                                    out_if.class_id, want.class_id));
    endtask

    task automatic push_item(input t_logit_item it, output bit got, output t_box bx);
        if (!no_idle) begin
            while ($urandom_range(99) < 27) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid        <= 1'b1;
        in_if.logit        <= it.logit;
        in_if.scale_sel    <= it.scale_sel;
        in_if.anchor_sel   <= it.anchor_sel;
        in_if.grid_col     <= it.grid_col;
        in_if.grid_row     <= it.grid_row;
        in_if.last_element <= it.last_element;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
        got = decode_logit(it, bx);
    endtask

    task automatic write_reg(input logic [ybd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ybd_pkg::CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            ybd_pkg::CFG_THRESHOLD: thr_q       = val[15:0];
            ybd_pkg::CFG_CLASSES:   ncls_q      = val[6:0];
            ybd_pkg::CFG_STRIDE0:   stride_q[0] = val[7:0];
            ybd_pkg::CFG_STRIDE1:   stride_q[1] = val[7:0];
            ybd_pkg::CFG_STRIDE2:   stride_q[2] = val[7:0];
            ybd_pkg::CFG_ANCHORS0:  anchor_q[0] = val[59:0];
            ybd_pkg::CFG_ANCHORS1:  anchor_q[1] = val[59:0];
            ybd_pkg::CFG_ANCHORS2:  anchor_q[2] = val[59:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic new_setting(input int p);
        logic [15:0] th;
        logic [6:0]  nc;
        logic [7:0]  st [3];
        logic [59:0] an [3];
        settle();
        case ($urandom_range(3))
            0: th = 16'd0;
            1: th = 16'($urandom_range(0, 16384));
            2: th = 16'($urandom_range(0, 65535));
            default: th = 16'($urandom_range(0, 40000));
        endcase
        case ($urandom_range(9))
            0: nc = 7'd0;
            1: nc = 7'd80;
            2: nc = 7'($urandom_range(81, 127));
            default: nc = 7'($urandom_range(1, 8));
        endcase
        for (int i = 0; i < 3; i++) begin
            st[i] = 8'($urandom);
            an[i] = ($urandom_range(7) == 0) ? '1 : 60'({$urandom, $urandom});
        end
        if (p == 0) begin
            th = 16'd0;
            nc = 7'd1;
            st = '{8'd1, 8'd1, 8'd1};
            an = '{60'd0, 60'd0, 60'd0};
        end else if (p == 1) begin
            th = 16'hFFFF;
            nc = 7'h7F;
            st = '{8'hFF, 8'hFF, 8'hFF};
            an = '{'1, '1, '1};
        end else if (p == 3) begin
            // most predictions emit while the output is held off
            th = 16'd0;
            nc = 7'd2;
        end
        write_reg(ybd_pkg::CFG_THRESHOLD, 60'(th));
        write_reg(ybd_pkg::CFG_CLASSES, 60'(nc));
        write_reg(ybd_pkg::CFG_STRIDE0, 60'(st[0]));
        write_reg(ybd_pkg::CFG_STRIDE1, 60'(st[1]));
        write_reg(ybd_pkg::CFG_STRIDE2, 60'(st[2]));
        write_reg(ybd_pkg::CFG_ANCHORS0, an[0]);
        write_reg(ybd_pkg::CFG_ANCHORS1, an[1]);
        write_reg(ybd_pkg::CFG_ANCHORS2, an[2]);
        cfg_we <= 1'b0;
    endtask

    task automatic random_prediction();
        int                 len;
        int                 nc;
        int                 pick;
        t_logit_item        it;
        bit                 got;
        t_box               bx;
        logic signed [15:0] prev_cls;
        nc = int'(ncls_q);
        if (nc < 1) nc = 1;
        if (nc > ybd_pkg::MAX_CLASSES) nc = ybd_pkg::MAX_CLASSES;
        pick = int'($urandom_range(99));
        if (pick < 78)
            len = 5 + nc + (($urandom_range(7) == 0) ? int'($urandom_range(1, 3)) : 0);
        else if (pick < 88)
            len = int'($urandom_range(1, 5));
        else if (pick < 96)
            len = int'($urandom_range(6, 5 + nc));
        else
            len = ($urandom_range(3) == 0) ? int'($urandom_range(128, 140))
                                           : int'($urandom_range(6, 24));
        prev_cls = '0;
        for (int k = 0; k < len; k++) begin
            it.logit = 16'($urandom);
            if (k >= 4 && $urandom_range(3) != 0) it.logit = 16'($urandom_range(256, 32767));
            if (k >= 6 && $urandom_range(4) == 0) it.logit = prev_cls;
            if (k >= 5) prev_cls = it.logit;
            it.scale_sel    = 2'($urandom);
            it.anchor_sel   = 2'($urandom);
            it.grid_col     = 8'($urandom);
            it.grid_row     = 8'($urandom);
            it.last_element = (k == len - 1);
            push_item(it, got, bx);
            if (got) pending_boxes.push_back(bx);
        end
    endtask

    initial begin : box_sink
        int hold;
        hold = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) check_box();
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = 300;
            end
            if (hold > 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= no_idle || ($urandom_range(99) >= 27);
            end
        end
    end

    initial begin : stimulus
        t_stim_row r;
        bit        got;
        t_box      bx;
        int        phase;
        int        start;
        in_if.valid        <= 1'b0;
        in_if.logit        <= '0;
        in_if.scale_sel    <= '0;
        in_if.anchor_sel   <= '0;
        in_if.grid_col     <= '0;
        in_if.grid_row     <= '0;
        in_if.last_element <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= '0;
        cfg_data           <= '0;
        i_rst_n            <= 1'b0;
        mismatches = 0;
        items_sent = 0;
        boxes_seen = 0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        thr_q      = 16'd16384;
        ncls_q     = 7'd80;
        stride_q   = '{8'd8, 8'd16, 8'd32};
        anchor_q   = '{60'd0, 60'd0, 60'd0};
        elem_n     = 0;
        cx = 0; cy = 0; bw = 0; bh = 0;
        obj = 0; best = 0; best_cls = 0;
        fill_logistic_tab();

        // last flag on the first element
        dir_q.push_back(it_row(ROW_NONE, 16'h0000, 2'd0, 2'd0, 8'd0, 8'd0, 1'b1));
        // reset settings, zero anchors: point box at the cell centre
        dir_q.push_back(it_row(ROW_PRED, 16'h0000, 2'd0, 2'd0, 8'd0, 8'd0, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h0000, 2'd0, 2'd0, 8'd0, 8'd0, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h0000, 2'd0, 2'd0, 8'd0, 8'd0, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h0000, 2'd0, 2'd0, 8'd0, 8'd0, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h7FFF, 2'd0, 2'd0, 8'd0, 8'd0, 1'b0));
        r = it_row(ROW_BOX, 16'h7FFF, 2'd0, 2'd0, 8'd0, 8'd0, 1'b1);
        r.box = '{left: 20'sd64, top: 20'sd64, right: 20'sd64, bottom: 20'sd64,
                  confidence: 16'd65534, class_id: 7'd0};
        dir_q.push_back(r);
        dir_q.push_back(cfg_row(ybd_pkg::CFG_THRESHOLD, 60'd0));
        dir_q.push_back(cfg_row(ybd_pkg::CFG_CLASSES, 60'd1));
        dir_q.push_back(cfg_row(ybd_pkg::CFG_STRIDE0, 60'd128));
        dir_q.push_back(cfg_row(ybd_pkg::CFG_ANCHORS0, '1));
        // largest centre saturates every corner
        dir_q.push_back(it_row(ROW_PRED, 16'h7FFF, 2'd0, 2'd0, 8'hFF, 8'hFF, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h7FFF, 2'd0, 2'd0, 8'hFF, 8'hFF, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h8000, 2'd0, 2'd0, 8'hFF, 8'hFF, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h8000, 2'd0, 2'd0, 8'hFF, 8'hFF, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h7FFF, 2'd0, 2'd0, 8'hFF, 8'hFF, 1'b0));
        r = it_row(ROW_BOX, 16'h7FFF, 2'd0, 2'd0, 8'hFF, 8'hFF, 1'b1);
        r.box = '{left: 20'sh7FFFF, top: 20'sh7FFFF, right: 20'sh7FFFF,
                  bottom: 20'sh7FFFF, confidence: 16'd65534, class_id: 7'd0};
        dir_q.push_back(r);
        // lowest scores give zero confidence, not above a zero threshold
        dir_q.push_back(it_row(ROW_PRED, 16'h1234, 2'd1, 2'd2, 8'd17, 8'd3, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'hF00D, 2'd1, 2'd2, 8'd17, 8'd3, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h0321, 2'd1, 2'd2, 8'd17, 8'd3, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'hFE80, 2'd1, 2'd2, 8'd17, 8'd3, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h8000, 2'd1, 2'd2, 8'd17, 8'd3, 1'b0));
        dir_q.push_back(it_row(ROW_NONE, 16'h8000, 2'd1, 2'd2, 8'd17, 8'd3, 1'b1));
        dir_q.push_back(cfg_row(ybd_pkg::CFG_CLASSES, 60'd3));
        dir_q.push_back(cfg_row(ybd_pkg::CFG_STRIDE2, 60'd255));
        dir_q.push_back(cfg_row(ybd_pkg::CFG_ANCHORS2, 60'h0AB_CDE1_2345_6789));
        // selectors of 3, tied classes, a class past the count
        dir_q.push_back(it_row(ROW_PRED, 16'h0180, 2'd3, 2'd3, 8'd200, 8'd100, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'hFE00, 2'd3, 2'd3, 8'd200, 8'd100, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h0100, 2'd3, 2'd3, 8'd200, 8'd100, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h0050, 2'd3, 2'd3, 8'd200, 8'd100, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h0400, 2'd3, 2'd3, 8'd200, 8'd100, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h0200, 2'd3, 2'd3, 8'd200, 8'd100, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h0200, 2'd3, 2'd3, 8'd200, 8'd100, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h0600, 2'd3, 2'd3, 8'd200, 8'd100, 1'b0));
        dir_q.push_back(it_row(ROW_PRED, 16'h7000, 2'd3, 2'd3, 8'd200, 8'd100, 1'b1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < dir_q.size(); i++) begin
            r = dir_q[i];
            if (r.kind == ROW_CFG) begin
                if (i == 0 || dir_q[i-1].kind != ROW_CFG) settle();
                write_reg(r.reg_idx, r.reg_val);
                if (i + 1 == dir_q.size() || dir_q[i+1].kind != ROW_CFG) cfg_we <= 1'b0;
            end else begin
                push_item(r.it, got, bx);
                case (r.kind)
                    ROW_PRED: if (got) pending_boxes.push_back(bx);
                    ROW_BOX:  pending_boxes.push_back(r.box);
                    default: ;
                endcase
            end
        end

        phase = 0;
        while (phase < 8 || (boxes_seen < 40 && phase < 16)) begin
            new_setting(phase);
            no_idle = (phase == 2);
            if (phase == 3) hold_req = 1'b1;
            start = items_sent;
            while (items_sent - start < 100) random_prediction();
            phase++;
        end
        no_idle = 1'b0;
        settle();

        $display("covered %0d logit items and %0d boxes over %0d random register settings,",
                 items_sent, boxes_seen, phase);
        $display("with saturated corners, early last flags, long predictions and a held output");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
